>>> rtl/core/sapq_pkg.sv
`default_nettype none

package sapq_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;

  typedef enum logic [StatusW-1:0] {
    StDone  = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

  // Operation broadcast to every cell in the same cycle
  typedef struct packed {
    logic                     enq;
    logic                     deq;
    logic signed [ValueW-1:0] value;
  } cell_op_t;

  // One result transaction
  typedef struct packed {
    logic signed [ValueW-1:0] head_value;
    status_e                  status;
    logic [CountW-1:0]        count_after;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/sapq_cell.sv
`default_nettype none

module sapq_cell (
  input  wire                                         clk_i,
  input  wire                                         occupied_i,
  input  wire                                         left_keep_i,
  input  wire logic signed [sapq_pkg::ValueW-1:0]     left_value_i,
  input  wire logic signed [sapq_pkg::ValueW-1:0]     right_value_i,
  input  wire sapq_pkg::cell_op_t                     op_i,
  output logic                                        keep_o,
  output logic signed [sapq_pkg::ValueW-1:0]          value_o
);

  logic signed [sapq_pkg::ValueW-1:0] value_q, value_d;

  // Keep own place while holding a value no smaller than the newcomer:
  // equal values stay ahead, so ties leave oldest first.
  assign keep_o  = occupied_i && !(value_q < op_i.value);
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    if (op_i.enq) begin
      if (keep_o) begin
        value_d = value_q;
      end else if (left_keep_i) begin
        value_d = op_i.value;
      end else begin
        value_d = left_value_i;
      end
    end else if (op_i.deq) begin
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

`default_nettype wire

>>> rtl/core/sapq_out_buf.sv
`default_nettype none

module sapq_out_buf (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    push_i,
  input  wire sapq_pkg::result_t data_i,
  output logic                   full_o,
  output logic                   valid_o,
  input  wire                    stall_i,
  output sapq_pkg::result_t      data_o
);

  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  sapq_pkg::result_t out_q, out_d;
  sapq_pkg::result_t skid_q, skid_d;
  logic              pop;

  assign pop     = out_valid_q && !stall_i;
  assign full_o  = skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || pop) begin
      // advance: skid first, then the new transaction
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = push_i;
        skid_d       = data_i;
      end else begin
        out_d       = data_i;
        out_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_d       = data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

`default_nettype wire

>>> rtl/core/sorted_array_priority_queue_unit.sv
// Bounded max-first priority queue held in a row of DEPTH cells.
// Input channel (in_valid_i / in_stall_o): action_i = 0 enqueues item_value_i,
// action_i = 1 dequeues the largest stored value. Every input transaction
// yields exactly one output transaction on the result channel
// (out_valid_o / out_stall_i): head_value_o, status_o, count_after_o.
// Each cell compares its own entry with the incoming value in the same cycle,
// so the cell row takes one transaction per cycle while in_stall_o is low;
// the result is registered in the output buffer. The rate is set by the
// compare-and-shift across the cell row.
// Equal values keep arrival order. Enqueue when full reports StFull and
// stores nothing; dequeue when empty reports StEmpty; head_value_o is zero
// unless a dequeue succeeded. count_after_o carries the low five bits of
// the count.
// Results pass through a two-entry output buffer: while the receiver stalls,
// one further transaction is still accepted, then in_stall_o rises.
// Reset empties the queue and the output buffer; cell contents are not
// cleared, only the entry count.
`default_nettype none

module sorted_array_priority_queue_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      in_valid_i,
  output logic                                     in_stall_o,
  input  wire                                      action_i,
  input  wire logic signed [sapq_pkg::ValueW-1:0]  item_value_i,
  output logic                                     out_valid_o,
  input  wire                                      out_stall_i,
  output logic signed [sapq_pkg::ValueW-1:0]       head_value_o,
  output logic [sapq_pkg::StatusW-1:0]             status_o,
  output logic [sapq_pkg::CountW-1:0]              count_after_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic                    accept;
  logic [CntW-1:0]         count_q, count_d;
  logic                    is_full, is_empty;
  sapq_pkg::cell_op_t      op;
  sapq_pkg::result_t       res, res_out;
  logic [CntW+sapq_pkg::CountW-1:0] count_ext;
  logic                    buf_full;

  logic                                  keep_w  [DEPTH];
  logic signed [sapq_pkg::ValueW-1:0]    value_w [DEPTH];

  assign accept   = in_valid_i && !in_stall_o;
  assign is_full  = (count_q == CntW'(DEPTH));
  assign is_empty = (count_q == '0);

  // drop refused operations before they reach the cells
  assign op.enq   = accept && !action_i && !is_full;
  assign op.deq   = accept &&  action_i && !is_empty;
  assign op.value = item_value_i;

  always_comb begin
    count_d = count_q;
    if (op.enq) begin
      count_d = count_q + 1'b1;
    end else if (op.deq) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Cell row: entry 0 is the head. Left neighbour of the head behaves as a
  // keeping cell so an insertion at the head takes the new value; the tail
  // takes its own value on a dequeue.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                               left_keep;
    logic signed [sapq_pkg::ValueW-1:0] left_value;
    logic signed [sapq_pkg::ValueW-1:0] right_value;
    if (i == 0) begin : g_head
      assign left_keep  = 1'b1;
      assign left_value = item_value_i;
    end else begin : g_body
      assign left_keep  = keep_w[i-1];
      assign left_value = value_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_value = value_w[i];
    end else begin : g_inner
      assign right_value = value_w[i+1];
    end

    sapq_cell u_cell (
      .clk_i         (clk_i),
      .occupied_i    (CntW'(i) < count_q),
      .left_keep_i   (left_keep),
      .left_value_i  (left_value),
      .right_value_i (right_value),
      .op_i          (op),
      .keep_o        (keep_w[i]),
      .value_o       (value_w[i])
    );
  end

  assign count_ext = {{sapq_pkg::CountW{1'b0}}, count_d};

  always_comb begin
    res.head_value  = '0;
    res.status      = sapq_pkg::StDone;
    res.count_after = count_ext[sapq_pkg::CountW-1:0];
    if (!action_i && is_full) begin
      res.status = sapq_pkg::StFull;
    end else if (action_i && is_empty) begin
      res.status = sapq_pkg::StEmpty;
    end else if (action_i) begin
      res.head_value = value_w[0];
    end
  end

  sapq_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (res),
    .full_o  (buf_full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (res_out)
  );

  assign in_stall_o    = buf_full;
  assign head_value_o  = res_out.head_value;
  assign status_o      = res_out.status;
  assign count_after_o = res_out.count_after;

endmodule

`default_nettype wire

>>> tb/sapq_tb_pkg.sv
`timescale 1ns / 100ps

package sapq_tb_pkg;

  // Meaning of action_i on the input channel
  typedef enum logic {
    OpEnqueue = 1'b0,
    OpDequeue = 1'b1
  } queue_op_e;

endpackage

>>> tb/sapq_queue_checker.sv
`timescale 1ns / 100ps

module sapq_queue_checker
  import sapq_pkg::*;
  import sapq_tb_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic                     action_i,
  input  logic signed [ValueW-1:0] item_value_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic signed [ValueW-1:0] head_value_i,
  input  logic [StatusW-1:0]       status_i,
  input  logic [CountW-1:0]        count_after_i,
  output int unsigned              fail_count_o,
  output int unsigned              outstanding_o,
  output int unsigned              dequeued_o,
  output int unsigned              full_refusals_o,
  output int unsigned              empty_refusals_o
);

  logic signed [ValueW-1:0] stored_values [DEPTH];
  int unsigned              stored_count;
  result_t                  awaited_results [$];
  int unsigned              fail_count;
  int unsigned              dequeued;
  int unsigned              full_refusals;
  int unsigned              empty_refusals;

  assign fail_count_o     = fail_count;
  assign outstanding_o    = awaited_results.size();
  assign dequeued_o       = dequeued;
  assign full_refusals_o  = full_refusals;
  assign empty_refusals_o = empty_refusals;

  // Insert behind every entry >= value, or pop the head; return the result.
  function automatic result_t apply_queue_op(input queue_op_e op,
                                             input logic signed [ValueW-1:0] value);
    result_t     outcome;
    int unsigned slot;
    outcome.head_value = '0;
    outcome.status     = StDone;
    if (op == OpEnqueue) begin
      if (stored_count >= DEPTH) begin
        outcome.status = StFull;
        full_refusals++;
      end else begin
        slot = stored_count;
        while (slot > 0 && stored_values[slot-1] < value) begin
          stored_values[slot] = stored_values[slot-1];
          slot--;
        end
        stored_values[slot] = value;
        stored_count++;
      end
    end else begin
      if (stored_count == 0) begin
        outcome.status = StEmpty;
        empty_refusals++;
      end else begin
        outcome.head_value = stored_values[0];
        for (int unsigned i = 0; i + 1 < stored_count; i++) begin
          stored_values[i] = stored_values[i+1];
        end
        stored_count--;
        dequeued++;
      end
    end
    outcome.count_after = CountW'(stored_count);
    return outcome;
  endfunction

  function automatic void log_mismatch(input string what);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
  endfunction

  initial begin
    stored_count   = 0;
    fail_count     = 0;
    dequeued       = 0;
    full_refusals  = 0;
    empty_refusals = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin : channel_watch
    result_t predicted;
    if (!rst_ni) begin
      stored_count = 0;
      awaited_results.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        awaited_results.push_back(apply_queue_op(queue_op_e'(action_i), item_value_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          log_mismatch($sformatf("unexpected result: head %0d status %0d count %0d",
                                 head_value_i, status_i, count_after_i));
        end else begin
          predicted = awaited_results.pop_front();
          if (head_value_i !== predicted.head_value || status_i !== predicted.status ||
              count_after_i !== predicted.count_after) begin
            log_mismatch($sformatf({"expected head %0d status %0d count %0d, ",
                                    "got head %0d status %0d count %0d"},
                                   predicted.head_value, predicted.status,
                                   predicted.count_after, head_value_i, status_i,
                                   count_after_i));
          end
        end
      end
    end
  end

endmodule

>>> tb/sorted_array_priority_queue_unit_tb.sv
`timescale 1ns / 100ps

module sorted_array_priority_queue_unit_tb;
  import sapq_pkg::*;
  import sapq_tb_pkg::*;

  localparam int unsigned QueueDepth  = 16;
  localparam int unsigned RandomItems = 1750;
  // Final stretch of the random part runs with no idling on either side
  localparam int unsigned CalmItems   = 200;
  localparam int unsigned SegmentLen  = 50;

  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     in_valid_i   = 1'b0;
  logic                     action_i     = OpEnqueue;
  logic signed [ValueW-1:0] item_value_i = '0;
  logic                     out_stall_i  = 1'b0;
  wire                      in_stall_o;
  wire                      out_valid_o;
  wire signed [ValueW-1:0]  head_value_o;
  wire [StatusW-1:0]        status_o;
  wire [CountW-1:0]         count_after_o;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned dequeued;
  int unsigned full_refusals;
  int unsigned empty_refusals;
  int unsigned items_sent = 0;

  // Idling switches, flipped per segment of the random part
  bit sender_idling   = 1'b0;
  bit receiver_idling = 1'b0;

  always #10 clk_i = ~clk_i;

  sorted_array_priority_queue_unit #(
    .DEPTH(QueueDepth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .item_value_i (item_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .head_value_o (head_value_o),
    .status_o     (status_o),
    .count_after_o(count_after_o)
  );

  sapq_queue_checker #(
    .DEPTH(QueueDepth)
  ) result_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .action_i        (action_i),
    .item_value_i    (item_value_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .head_value_i    (head_value_o),
    .status_i        (status_o),
    .count_after_i   (count_after_o),
    .fail_count_o    (fail_count),
    .outstanding_o   (outstanding),
    .dequeued_o      (dequeued),
    .full_refusals_o (full_refusals),
    .empty_refusals_o(empty_refusals)
  );

  // Offer one transaction and hold it until the queue takes it. An optional
  // gap first drops valid for a burst of cycles; without a gap valid simply
  // stays high into the next transaction, so it is never lowered and raised
  // in the same time step.
  task automatic push_item(input queue_op_e op, input logic signed [ValueW-1:0] value);
    if (sender_idling && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= op;
    item_value_i <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Receiver side: stall the result channel in random bursts while allowed.
  // Between bursts the stall is released before the next can begin.
  initial begin
    forever begin
      @(posedge clk_i);
      if (receiver_idling && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    queue_op_e                op;
    logic signed [ValueW-1:0] value;
    int unsigned              enqueue_share;
    int unsigned              guard;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty refusal, extremes, ties, fill to full, full refusal
    push_item(OpDequeue, 32'sh1234_5678);
    push_item(OpEnqueue, 32'sh7FFF_FFFF);
    push_item(OpEnqueue, 32'sh8000_0000);
    push_item(OpEnqueue, 32'sh0000_0000);
    push_item(OpEnqueue, -32'sd1);
    push_item(OpEnqueue, 32'sd1);
    push_item(OpEnqueue, 32'sd5);
    push_item(OpEnqueue, 32'sd5);
    push_item(OpEnqueue, -32'sd5);
    push_item(OpDequeue, 32'sh0000_0000);
    for (int i = 0; i < 8; i++) begin
      push_item(OpEnqueue, 32'(100 * i - 400));
    end
    push_item(OpEnqueue, 32'sh7FFF_FFFF);
    // Queue now holds 16 entries: both extremes must be refused
    push_item(OpEnqueue, 32'sh7FFF_FFFF);
    push_item(OpEnqueue, 32'sh8000_0000);
    push_item(OpDequeue, 32'shFFFF_FFFF);
    push_item(OpDequeue, 32'sh0000_0000);
    push_item(OpEnqueue, 32'sh8000_0000);

    // Random part: segments with a varying enqueue share drive the count
    // from empty to full and back, so both refusals come up repeatedly.
    for (int unsigned n = 0; n < RandomItems; n++) begin
      if (n % SegmentLen == 0) begin
        case ($urandom_range(0, 4))
          0:       enqueue_share = 10;
          1:       enqueue_share = 30;
          2:       enqueue_share = 50;
          3:       enqueue_share = 70;
          default: enqueue_share = 90;
        endcase
        sender_idling   = (n < RandomItems - CalmItems) && $urandom_range(0, 2) != 0;
        receiver_idling = (n < RandomItems - CalmItems) && $urandom_range(0, 2) != 0;
      end
      op = ($urandom_range(1, 100) <= enqueue_share) ? OpEnqueue : OpDequeue;
      // Favour a narrow range so that equal values meet often
      case ($urandom_range(0, 7))
        0, 1:    value = int'($urandom_range(0, 8)) - 4;
        2:       value = 32'sh7FFF_FFFF - int'($urandom_range(0, 2));
        3:       value = 32'sh8000_0000 + int'($urandom_range(0, 2));
        4:       value = int'($urandom_range(0, 2000)) - 1000;
        default: value = $urandom;
      endcase
      push_item(op, value);
    end
    in_valid_i <= 1'b0;
    sender_idling   = 1'b0;
    receiver_idling = 1'b0;

    // Drain: wait for every outstanding result, then keep watching the result
    // channel for anything spurious before the summary.
    guard = 0;
    @(negedge clk_i);
    while (outstanding != 0 && guard < 2000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);

    $display("Sent %0d transactions: %0d values dequeued, %0d full and %0d empty refusals.",
             items_sent, dequeued, full_refusals, empty_refusals);
    if (fail_count == 0 && outstanding == 0) begin
      $display("sorted_array_priority_queue_unit_tb OK");
    end else begin
      $display("sorted_array_priority_queue_unit_tb NOT OK");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legitimate run
  initial begin
    #20_000_000;
    $display("sorted_array_priority_queue_unit_tb NOT OK");
    $finish;
  end

endmodule
